// File: hdl/lowest_free_descriptor_allocator_unit_defines.svh
// assertion macros shared by the allocator checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef LOWEST_FREE_DESCRIPTOR_ALLOCATOR_UNIT_DEFINES_SVH
`define LOWEST_FREE_DESCRIPTOR_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LFDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfda assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LFDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfda assertion failed");

`endif

// File: hdl/lfda_pkg.sv
// types and constants of the lowest-free descriptor allocator
// no dependencies; used by every allocator module and the checker
package lfda_pkg;

    localparam int SLOT_W = 9;
    localparam int NUM_W  = 8;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [NUM_W-1:0]  num_t;

    // granted numbers are 8 bits, so a larger limit acts as this
    localparam slot_t LIMIT_CAP   = 9'd256;
    localparam slot_t LIMIT_RESET = 9'd256;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef struct packed {
        logic op;
        num_t search_start;
        logic want_close_on_exec;
        num_t release_number;
    } item_t;

    typedef struct packed {
        logic status;
        num_t granted_number;
    } result_t;

    typedef struct packed {
        logic  found;
        slot_t slot;
    } hit_t;

endpackage

// File: hdl/lfda_search.sv
// two-level lowest-free search: per-word find-first, then first non-empty word
// depends on lfda_pkg; instantiated by lfda_state
module lfda_search #(
    parameter int WORD_BITS  = 64,
    parameter int LIVE_WORDS = 4,
    parameter int LIVE_SLOTS = 256
) (
    input  logic [LIVE_WORDS*WORD_BITS-1:0] open_map,
    input  logic [LIVE_WORDS-1:0]           full_map,
    input  lfda_pkg::slot_t                 from,
    output lfda_pkg::hit_t                  hit,
    output logic [LIVE_WORDS*WORD_BITS-1:0] grant_onehot
);

    localparam int MAP_BITS = LIVE_WORDS * WORD_BITS;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int WIDX_W   = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;

    logic [MAP_BITS-1:0]                   avail;
    logic [MAP_BITS-1:0]                   lowest;
    logic [LIVE_WORDS-1:0]                 word_any;
    logic [LIVE_WORDS-1:0]                 word_sel;
    logic [LIVE_WORDS-1:0][BIT_W-1:0]      bit_idx;
    logic [WIDX_W-1:0]                     word_idx;
    logic [BIT_W-1:0]                      bit_sel;

    // free, at or above the start, in a word not marked full, inside the table
    always_comb
    begin
        for (int i = 0; i < MAP_BITS; i++)
        begin
            avail[i] = !open_map[i] && !full_map[i / WORD_BITS] && (i < LIVE_SLOTS)
                       && (lfda_pkg::slot_t'(i) >= from);
        end
    end

    always_comb
    begin
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] low;
        for (int w = 0; w < LIVE_WORDS; w++)
        begin
            v   = avail[w*WORD_BITS +: WORD_BITS];
            // isolate the lowest set bit
            low = v & (~v + WORD_BITS'(1));
            lowest[w*WORD_BITS +: WORD_BITS] = low;
            word_any[w] = |v;
            bit_idx[w]  = '0;
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (low[b])
                begin
                    bit_idx[w] = bit_idx[w] | BIT_W'(b);
                end
            end
        end
    end

    assign word_sel = word_any & (~word_any + LIVE_WORDS'(1));

    always_comb
    begin
        word_idx = '0;
        bit_sel  = '0;
        for (int w = 0; w < LIVE_WORDS; w++)
        begin
            if (word_sel[w])
            begin
                word_idx = word_idx | WIDX_W'(w);
                bit_sel  = bit_sel | bit_idx[w];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAP_BITS; i++)
        begin
            grant_onehot[i] = lowest[i] & word_sel[i / WORD_BITS];
        end
    end

    assign hit.found = |word_any;
    assign hit.slot  = lfda_pkg::slot_t'(word_idx) * lfda_pkg::slot_t'(WORD_BITS)
                       + lfda_pkg::slot_t'(bit_sel);

endmodule

// File: hdl/lfda_state.sv
// descriptor bitmaps, full-word summary, close-on-exec map and next-free hint
// depends on lfda_pkg and lfda_search; instantiated by the top level
module lfda_state #(
    parameter int TABLE_SLOTS = 256,
    parameter int WORD_BITS   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  lfda_pkg::item_t   item,
    input  lfda_pkg::slot_t   limit,
    output lfda_pkg::result_t result
);

    // only slots below 256 can ever be granted
    localparam int LIVE_SLOTS = (TABLE_SLOTS < 256) ? TABLE_SLOTS : 256;
    localparam int LIVE_WORDS = (LIVE_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_BITS   = LIVE_WORDS * WORD_BITS;

    logic [MAP_BITS-1:0]   open_map_reg, open_map_next;
    logic [MAP_BITS-1:0]   exec_close_map_reg, exec_close_map_next;
    logic [LIVE_WORDS-1:0] full_word_map_reg, full_word_map_next;
    lfda_pkg::slot_t       next_free_hint_reg, next_free_hint_next;

    lfda_pkg::slot_t       start;
    lfda_pkg::slot_t       rel;
    lfda_pkg::slot_t       from;
    lfda_pkg::slot_t       lim_eff;
    lfda_pkg::hit_t        hit;
    logic [MAP_BITS-1:0]   grant_onehot;
    logic [MAP_BITS-1:0]   rel_onehot;
    logic [LIVE_WORDS-1:0] rel_word;
    logic                  rel_in;
    logic                  alloc_ok;
    logic                  is_alloc;

    assign start    = lfda_pkg::slot_t'(item.search_start);
    assign rel      = lfda_pkg::slot_t'(item.release_number);
    assign from     = (start < next_free_hint_reg) ? next_free_hint_reg : start;
    assign lim_eff  = (limit > lfda_pkg::LIMIT_CAP) ? lfda_pkg::LIMIT_CAP : limit;
    assign is_alloc = (item.op == lfda_pkg::OP_ALLOC);

    lfda_search #(
        .WORD_BITS  (WORD_BITS),
        .LIVE_WORDS (LIVE_WORDS),
        .LIVE_SLOTS (LIVE_SLOTS)
    ) u_search (
        .open_map     (open_map_reg),
        .full_map     (full_word_map_reg),
        .from         (from),
        .hit          (hit),
        .grant_onehot (grant_onehot)
    );

    assign alloc_ok = hit.found && (hit.slot < lim_eff);

    // releases beyond the table change nothing
    assign rel_in     = rel < lfda_pkg::slot_t'(LIVE_SLOTS);
    assign rel_onehot = rel_in ? (MAP_BITS'(1) << item.release_number) : '0;

    always_comb
    begin
        for (int w = 0; w < LIVE_WORDS; w++)
        begin
            rel_word[w] = |rel_onehot[w*WORD_BITS +: WORD_BITS];
        end
    end

    always_comb
    begin
        open_map_next       = open_map_reg;
        exec_close_map_next = exec_close_map_reg;
        full_word_map_next  = full_word_map_reg;
        next_free_hint_next = next_free_hint_reg;
        if (fire)
        begin
            if (!is_alloc)
            begin
                open_map_next      = open_map_reg & ~rel_onehot;
                full_word_map_next = full_word_map_reg & ~rel_word;
                if (rel_in && (rel < next_free_hint_reg))
                begin
                    next_free_hint_next = rel;
                end
            end
            else if (alloc_ok)
            begin
                open_map_next = open_map_reg | grant_onehot;
                if (item.want_close_on_exec)
                begin
                    exec_close_map_next = exec_close_map_reg | grant_onehot;
                end
                else
                begin
                    exec_close_map_next = exec_close_map_reg & ~grant_onehot;
                end
                for (int w = 0; w < LIVE_WORDS; w++)
                begin
                    full_word_map_next[w] = full_word_map_reg[w]
                                            | (&open_map_next[w*WORD_BITS +: WORD_BITS]);
                end
                // a search started above the hint leaves the hint alone
                if (start <= next_free_hint_reg)
                begin
                    next_free_hint_next = hit.slot + lfda_pkg::slot_t'(1);
                end
            end
        end
    end

    always_comb
    begin
        result.status         = lfda_pkg::STATUS_OK;
        result.granted_number = '0;
        if (is_alloc)
        begin
            if (alloc_ok)
            begin
                result.granted_number = hit.slot[lfda_pkg::NUM_W-1:0];
            end
            else
            begin
                result.status = lfda_pkg::STATUS_NO_FREE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_map_reg       <= '0;
            exec_close_map_reg <= '0;
            full_word_map_reg  <= '0;
            next_free_hint_reg <= '0;
        end
        else
        begin
            open_map_reg       <= open_map_next;
            exec_close_map_reg <= exec_close_map_next;
            full_word_map_reg  <= full_word_map_next;
            next_free_hint_reg <= next_free_hint_next;
        end
    end

endmodule

// File: hdl/lowest_free_descriptor_allocator_unit.sv
// top level of the lowest-free descriptor allocator: input and result registers
// depends on lfda_pkg and lfda_state
// One result per transaction. An accepted transaction waits in the input register until the
// result register is free or being emptied; there a combinational two-level priority search
// over the open bitmap (per-word find-first, then first word with a free slot) picks the slot
// and updates all state, and the result register takes the result as the transaction advances. A new
// transaction is taken every cycle as long as results are taken, so the sustained rate is one
// per cycle. No clearing pass after reset: the bitmaps reset directly. The limit register may
// be written only while no transaction is in flight.
module lowest_free_descriptor_allocator_unit #(
    parameter int TABLE_SLOTS = 256,
    parameter int WORD_BITS   = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] descriptor_limit,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] search_start,
    input  logic       want_close_on_exec,
    input  logic [7:0] release_number,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       status,
    output logic [7:0] granted_number
);

    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    lfda_pkg::slot_t   limit_reg;
    lfda_pkg::item_t   item_reg;
    lfda_pkg::result_t result_reg;
    lfda_pkg::result_t result;
    logic              advance;
    logic              in_take;

    assign cfg_ready = 1'b1;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    lfda_state #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .WORD_BITS   (WORD_BITS)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .limit  (limit_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= lfda_pkg::LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= descriptor_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op                 <= op;
            item_reg.search_start       <= search_start;
            item_reg.want_close_on_exec <= want_close_on_exec;
            item_reg.release_number     <= release_number;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign granted_number = result_reg.granted_number;

endmodule

// File: hdl/lfda_checker.sv
// port-level checker for the allocator, bound to the top level
// depends on lfda_pkg and the assertion macros header
`include "lowest_free_descriptor_allocator_unit_defines.svh"

module lfda_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       status,
    input logic [7:0] granted_number
);

    logic       out_stall;
    logic       out_fail;
    logic       in_fire;
    logic [8:0] out_word;

    assign out_stall = out_valid && !out_ready;
    assign out_fail  = out_valid && (status == lfda_pkg::STATUS_NO_FREE);
    assign in_fire   = in_valid && in_ready;
    assign out_word  = {status, granted_number};

    // a stalled result holds
    `LFDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

    // a failed allocation reports number zero
    `LFDA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_fail, granted_number == 8'd0)

    // input backpressure only comes from a stalled result
    `LFDA_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_stall)

    // a fresh result comes from a transaction that passed the input and result registers without a stall
    `LFDA_ASSERT_NOW(a_result_origin, clk, rst_n, $rose(out_valid), $past(in_fire, 2))

endmodule

bind lowest_free_descriptor_allocator_unit lfda_checker u_lfda_checker (.*);

// File: test/lowest_free_descriptor_allocator_unit_tb.sv
// self-checking testbench of lowest_free_descriptor_allocator_unit: directed and random
// allocate/release transactions, limit writes, a bitmap predictor and an in-order scoreboard
// depends on lfda_pkg and the allocator rtl
module lowest_free_descriptor_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 256;
    localparam int WORD       = 64;
    localparam int WORDS      = SLOTS / WORD;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 220;

    class descriptor_table_scoreboard;
        bit [SLOTS-1:0]    open_slots;
        bit [SLOTS-1:0]    exec_close_marks;
        bit [WORDS-1:0]    full_words;
        lfda_pkg::slot_t   next_hint;
        lfda_pkg::slot_t   limit;
        lfda_pkg::result_t pending_grants[$];
        int                faults;

        function new();
            open_slots       = '0;
            exec_close_marks = '0;
            full_words       = '0;
            next_hint        = '0;
            limit            = lfda_pkg::LIMIT_RESET;
            faults           = 0;
        endfunction

        function void set_limit(lfda_pkg::slot_t value);
            limit = value;
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction

        // lowest free slot at or above from, skipping words marked full; SLOTS when none
        function int lowest_free(int from);
            for (int s = from; s < SLOTS; s++)
                if (!full_words[s / WORD] && !open_slots[s])
                    return s;
            return SLOTS;
        endfunction

        // a currently open slot if there is one, so releases mostly hit live descriptors
        function lfda_pkg::num_t pick_open();
            int base;
            base = $urandom_range(SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
                if (open_slots[(base + k) % SLOTS])
                    return lfda_pkg::num_t'((base + k) % SLOTS);
            return lfda_pkg::num_t'(base);
        endfunction

        function void note_request(lfda_pkg::item_t req);
            lfda_pkg::result_t grant;
            int                cap;
            int                cand;
            int                w;
            grant.status         = lfda_pkg::STATUS_OK;
            grant.granted_number = '0;
            if (req.op == lfda_pkg::OP_RELEASE)
            begin
                open_slots[req.release_number]              = 1'b0;
                full_words[int'(req.release_number) / WORD] = 1'b0;
                if (req.release_number < next_hint)
                    next_hint = lfda_pkg::slot_t'(req.release_number);
            end
            else
            begin
                cap  = (limit > lfda_pkg::LIMIT_CAP) ? int'(lfda_pkg::LIMIT_CAP) : int'(limit);
                cand = int'(req.search_start);
                if (cand < int'(next_hint))
                    cand = int'(next_hint);
                cand = lowest_free(cand);
                if (cand >= cap || cand >= SLOTS)
                begin
                    grant.status = lfda_pkg::STATUS_NO_FREE;
                end
                else
                begin
                    if (req.search_start <= next_hint)
                        next_hint = lfda_pkg::slot_t'(cand + 1);
                    open_slots[cand] = 1'b1;
                    w = cand / WORD;
                    if (&open_slots[w*WORD +: WORD])
                        full_words[w] = 1'b1;
                    exec_close_marks[cand] = req.want_close_on_exec;
                    grant.granted_number   = lfda_pkg::num_t'(cand);
                end
            end
            pending_grants.push_back(grant);
        endfunction

        function void check_result(lfda_pkg::result_t got);
            lfda_pkg::result_t want;
            if (pending_grants.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: status %0d number %0d",
                             got.status, got.granted_number);
                return;
            end
            want = pending_grants.pop_front();
            if (got.status !== want.status || got.granted_number !== want.granted_number)
            begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected status %0d number %0d, got status %0d number %0d",
                             want.status, want.granted_number, got.status, got.granted_number);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] descriptor_limit;
    logic       in_valid;
    logic       in_ready;
    logic       op;
    logic [7:0] search_start;
    logic       want_close_on_exec;
    logic [7:0] release_number;
    logic       out_valid;
    logic       out_ready;
    logic       status;
    logic [7:0] granted_number;

    descriptor_table_scoreboard book;
    int source_gap_pct;
    int sink_stall_pct;

    lowest_free_descriptor_allocator_unit #(
        .TABLE_SLOTS (SLOTS),
        .WORD_BITS   (WORD)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .descriptor_limit   (descriptor_limit),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .search_start       (search_start),
        .want_close_on_exec (want_close_on_exec),
        .release_number     (release_number),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .granted_number     (granted_number)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic lfda_pkg::item_t pack_request(logic o, int start, logic coe, int rel);
        lfda_pkg::item_t req;
        req.op                 = o;
        req.search_start       = lfda_pkg::num_t'(start);
        req.want_close_on_exec = coe;
        req.release_number     = lfda_pkg::num_t'(rel);
        return req;
    endfunction

    function automatic lfda_pkg::item_t random_request(int alloc_pct);
        lfda_pkg::item_t req;
        int              pick;
        req.op = ($urandom_range(99) < alloc_pct) ? lfda_pkg::OP_ALLOC : lfda_pkg::OP_RELEASE;
        pick = $urandom_range(5);
        if (pick < 3)
            req.search_start = '0;
        else if (pick == 3)
            req.search_start = lfda_pkg::num_t'($urandom_range(15));
        else
            req.search_start = lfda_pkg::num_t'($urandom_range(255));
        req.want_close_on_exec = 1'($urandom_range(1));
        if (req.op == lfda_pkg::OP_RELEASE && $urandom_range(99) < 80)
            req.release_number = book.pick_open();
        else
            req.release_number = lfda_pkg::num_t'($urandom_range(255));
        return req;
    endfunction

    task automatic send_request(lfda_pkg::item_t req);
        while ($urandom_range(99) < source_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        op                 <= req.op;
        search_start       <= req.search_start;
        want_close_on_exec <= req.want_close_on_exec;
        release_number     <= req.release_number;
        do @(posedge clk); while (!in_ready);
        book.note_request(req);
    endtask

    task automatic wait_drained();
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // limit is only written with nothing in flight
    task automatic write_limit(lfda_pkg::slot_t value);
        in_valid <= 1'b0;
        wait_drained();
        cfg_valid        <= 1'b1;
        descriptor_limit <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.set_limit(value);
    endtask

    initial
    begin : result_sink
        lfda_pkg::result_t got;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.status         = status;
                got.granted_number = granted_number;
                book.check_result(got);
            end
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin : stimulus
        lfda_pkg::slot_t phase_limit [PHASES];
        int              phase_alloc [PHASES];
        book = new();
        phase_limit = '{9'd200, 9'd64, 9'd511, 9'd1, 9'd300, 9'd256};
        phase_alloc = '{85, 50, 80, 45, 65, 70};
        source_gap_pct = 18;
        sink_stall_pct = 76;
        rst_n              <= 1'b0;
        cfg_valid          <= 1'b0;
        descriptor_limit   <= '0;
        in_valid           <= 1'b0;
        op                 <= lfda_pkg::OP_ALLOC;
        search_start       <= '0;
        want_close_on_exec <= 1'b0;
        release_number     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hint movement, start above hint, table end, free and repeated releases
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b0, 255));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   255, 1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   255, 1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   128, 1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   3,   1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 255, 1'b1, 1));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 0,   1'b0, 1));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 0,   1'b0, 255));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 0,   1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 0,   1'b0, 77));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b1, 255));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   254, 1'b0, 170));
        write_limit(9'd0);
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   255, 1'b1, 85));
        send_request(pack_request(lfda_pkg::OP_RELEASE, 0,   1'b0, 128));
        write_limit(9'd511);
        send_request(pack_request(lfda_pkg::OP_ALLOC,   200, 1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   255, 1'b0, 0));
        write_limit(9'd2);
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b0, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   0,   1'b1, 0));
        send_request(pack_request(lfda_pkg::OP_ALLOC,   1,   1'b0, 0));

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            source_gap_pct = (p < 2) ? 18 : (p < 4) ? 76 : 0;
            sink_stall_pct = (p < 2) ? 76 : (p < 4) ? 18 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(phase_alloc[p]));
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (book.faults == 0 && book.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
